// File: sv/cvsm_pkg.sv
// shared types, codes and constants of the consensus vote state manager
`timescale 1ns / 1ps

package cvsm_pkg;

    // default parameter values
    localparam int NUM_STATES_DEF  = 16;
    localparam int RESET_STATE_DEF = 0;

    // field widths
    localparam int CMD_W   = 3;
    localparam int STATE_W = 4;
    localparam int CONF_W  = 8;
    localparam int TAG_W   = 32;
    localparam int CNT_W   = 8;
    localparam int LEN_W   = 4;
    localparam int TMO_W   = 16;
    localparam int KIND_W  = 2;
    localparam int VOTE_W  = 2;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 48;

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_ALIAS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_APPROVALS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VETOES     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VETO_CONF      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_APPROVE_CONF   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ABORT_STATE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 3'd6;

    // register reset values
    localparam logic [CNT_W-1:0]   MIN_APPROVALS_RST = 8'd1;
    localparam logic [CNT_W-1:0]   MAX_VETOES_RST    = 8'd0;
    localparam logic [CONF_W-1:0]  VETO_CONF_RST     = 8'd64;
    localparam logic [CONF_W-1:0]  APPROVE_CONF_RST  = 8'd192;
    localparam logic [STATE_W-1:0] ABORT_STATE_RST   = 4'd1;
    localparam logic [TMO_W-1:0]   TIMEOUT_TICKS_RST = 16'd100;

    // event commands
    localparam logic [CMD_W-1:0] CMD_CONF_UPDATE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START_REQ   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEER_REQ    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEER_VOTE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK        = 3'd4;

    // message kinds
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VOTE    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_COMMIT  = 2'd3;

    // our vote codes
    localparam logic [VOTE_W-1:0] REPLY_APPROVE = 2'd0;
    localparam logic [VOTE_W-1:0] REPLY_VETO    = 2'd1;
    localparam logic [VOTE_W-1:0] REPLY_ABSTAIN = 2'd2;

    // peer vote codes
    localparam logic [CNT_W-1:0] PEER_APPROVE = 8'd0;
    localparam logic [CNT_W-1:0] PEER_VETO    = 8'd1;

    // shortest accepted peer messages
    localparam logic [LEN_W-1:0] MIN_REQ_LEN  = 4'd6;
    localparam logic [LEN_W-1:0] MIN_VOTE_LEN = 4'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [STATE_W-1:0] target_state;
        logic [CONF_W-1:0]  confidence_value;
        logic [TAG_W-1:0]   request_tag;
        logic [CNT_W-1:0]   vote_code;
        logic [CNT_W-1:0]   live_boards;
        logic [LEN_W-1:0]   payload_length;
    } event_t;

    typedef struct packed {
        logic [KIND_W-1:0]  message_kind;
        logic [TAG_W-1:0]   message_tag;
        logic [STATE_W-1:0] message_state;
        logic [VOTE_W-1:0]  our_vote;
        logic [STATE_W-1:0] committed_state;
        logic               request_pending;
    } result_t;

    // handshake between the stages
    typedef struct packed {
        logic valid;
        logic advance;
    } flow_t;

endpackage

// File: sv/cvsm_in_stage.sv
// input register stage: holds one accepted event until the engine takes it
`timescale 1ns / 1ps

module cvsm_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cvsm_pkg::event_t    in_event,
    input  logic                advance,
    output logic                ev_valid,
    output cvsm_pkg::event_t    ev
);

    logic             valid_reg;
    logic             valid_next;
    cvsm_pkg::event_t ev_reg;
    logic             load;

    assign in_ready   = !valid_reg || advance;
    assign load       = in_valid && in_ready;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ev_reg <= in_event;
        end
    end

    assign ev_valid = valid_reg;
    assign ev       = ev_reg;

endmodule

// File: sv/cvsm_engine.sv
// event engine: config registers, confidence table, pending request and commit logic
`timescale 1ns / 1ps

module cvsm_engine
#(
    parameter int NUM_STATES  = cvsm_pkg::NUM_STATES_DEF,
    parameter int RESET_STATE = cvsm_pkg::RESET_STATE_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cvsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cvsm_pkg::CFG_DW-1:0]       cfg_data,
    input  cvsm_pkg::flow_t                   flow,
    input  cvsm_pkg::event_t                  ev,
    output cvsm_pkg::result_t                 res
);

    // only states reachable by a 4-bit code need storage
    localparam int TBL_DEPTH = (NUM_STATES < (1 << cvsm_pkg::STATE_W)) ?
                               NUM_STATES : (1 << cvsm_pkg::STATE_W);
    localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    logic fire;

    // configuration
    logic [cvsm_pkg::CNT_W-1:0]   min_app_reg;
    logic [cvsm_pkg::CNT_W-1:0]   max_veto_reg;
    logic [cvsm_pkg::CONF_W-1:0]  veto_conf_reg;
    logic [cvsm_pkg::CONF_W-1:0]  app_conf_reg;
    logic [cvsm_pkg::STATE_W-1:0] abort_reg;
    logic [cvsm_pkg::TMO_W-1:0]   tmo_ticks_reg;

    // request state
    logic [cvsm_pkg::STATE_W-1:0] sys_reg,   sys_next;
    logic                         pend_reg,  pend_next;
    logic [cvsm_pkg::STATE_W-1:0] pst_reg,   pst_next;
    logic [cvsm_pkg::TAG_W-1:0]   ptag_reg,  ptag_next;
    logic [cvsm_pkg::CNT_W-1:0]   vrem_reg,  vrem_next;
    logic [cvsm_pkg::CNT_W-1:0]   app_reg,   app_next;
    logic [cvsm_pkg::CNT_W-1:0]   veto_reg,  veto_next;
    logic [cvsm_pkg::TMO_W-1:0]   tmo_reg,   tmo_next;

    logic [cvsm_pkg::CONF_W-1:0]  tbl_reg [TBL_DEPTH];
    logic                         tbl_we;
    logic                         tgt_ok;
    logic [TBL_AW-1:0]            tbl_idx;
    logic [cvsm_pkg::CONF_W-1:0]  conf_rd;
    logic [cvsm_pkg::VOTE_W-1:0]  vote_pick;

    logic [cvsm_pkg::CNT_W-1:0]   app_inc;
    logic [cvsm_pkg::CNT_W-1:0]   veto_inc;
    logic [cvsm_pkg::CNT_W-1:0]   vrem_dec;

    assign fire = flow.valid && flow.advance;

    // configuration writes; own_alias feeds no result field, so it is not kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_app_reg   <= cvsm_pkg::MIN_APPROVALS_RST;
            max_veto_reg  <= cvsm_pkg::MAX_VETOES_RST;
            veto_conf_reg <= cvsm_pkg::VETO_CONF_RST;
            app_conf_reg  <= cvsm_pkg::APPROVE_CONF_RST;
            abort_reg     <= cvsm_pkg::ABORT_STATE_RST;
            tmo_ticks_reg <= cvsm_pkg::TIMEOUT_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cvsm_pkg::REG_MIN_APPROVALS: min_app_reg   <= cfg_data[cvsm_pkg::CNT_W-1:0];
                cvsm_pkg::REG_MAX_VETOES:    max_veto_reg  <= cfg_data[cvsm_pkg::CNT_W-1:0];
                cvsm_pkg::REG_VETO_CONF:     veto_conf_reg <= cfg_data[cvsm_pkg::CONF_W-1:0];
                cvsm_pkg::REG_APPROVE_CONF:  app_conf_reg  <= cfg_data[cvsm_pkg::CONF_W-1:0];
                cvsm_pkg::REG_ABORT_STATE:   abort_reg     <= cfg_data[cvsm_pkg::STATE_W-1:0];
                cvsm_pkg::REG_TIMEOUT_TICKS: tmo_ticks_reg <= cfg_data[cvsm_pkg::TMO_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // confidence lookup and vote choice
    assign tgt_ok   = 32'(ev.target_state) < NUM_STATES;
    assign tbl_idx  = ev.target_state[TBL_AW-1:0];
    assign conf_rd  = tgt_ok ? tbl_reg[tbl_idx] : '0;

    always_comb
    begin
        if (conf_rd < veto_conf_reg)
        begin
            vote_pick = cvsm_pkg::REPLY_VETO;
        end
        else if (conf_rd > app_conf_reg)
        begin
            vote_pick = cvsm_pkg::REPLY_APPROVE;
        end
        else
        begin
            vote_pick = cvsm_pkg::REPLY_ABSTAIN;
        end
    end

    // saturating vote counters
    assign app_inc  = (ev.vote_code == cvsm_pkg::PEER_APPROVE && app_reg != cvsm_pkg::CNT_MAX) ?
                      app_reg + 8'd1 : app_reg;
    assign veto_inc = (ev.vote_code == cvsm_pkg::PEER_VETO && veto_reg != cvsm_pkg::CNT_MAX) ?
                      veto_reg + 8'd1 : veto_reg;
    assign vrem_dec = (vrem_reg != '0) ? vrem_reg - 8'd1 : vrem_reg;

    always_comb
    begin
        logic do_commit;
        logic do_clear;

        do_commit = 1'b0;
        do_clear  = 1'b0;
        sys_next  = sys_reg;
        pend_next = pend_reg;
        pst_next  = pst_reg;
        ptag_next = ptag_reg;
        vrem_next = vrem_reg;
        app_next  = app_reg;
        veto_next = veto_reg;
        tmo_next  = tmo_reg;
        tbl_we    = 1'b0;

        res.message_kind  = cvsm_pkg::KIND_NONE;
        res.message_tag   = '0;
        res.message_state = '0;
        res.our_vote      = cvsm_pkg::REPLY_ABSTAIN;

        if (fire)
        begin
            unique case (ev.command)
                cvsm_pkg::CMD_CONF_UPDATE:
                begin
                    tbl_we = tgt_ok;
                end
                cvsm_pkg::CMD_START_REQ:
                begin
                    // a new request replaces any pending one
                    pend_next         = 1'b1;
                    pst_next          = ev.target_state;
                    ptag_next         = ev.request_tag;
                    vrem_next         = ev.live_boards;
                    app_next          = '0;
                    veto_next         = '0;
                    tmo_next          = tmo_ticks_reg;
                    res.message_kind  = cvsm_pkg::KIND_REQUEST;
                    res.message_tag   = ev.request_tag;
                    res.message_state = ev.target_state;
                end
                cvsm_pkg::CMD_PEER_REQ:
                begin
                    if (ev.payload_length >= cvsm_pkg::MIN_REQ_LEN)
                    begin
                        res.message_kind = cvsm_pkg::KIND_VOTE;
                        res.message_tag  = ev.request_tag;
                        res.our_vote     = vote_pick;
                    end
                end
                cvsm_pkg::CMD_PEER_VOTE:
                begin
                    if (ev.payload_length >= cvsm_pkg::MIN_VOTE_LEN && pend_reg &&
                        ev.request_tag == ptag_reg)
                    begin
                        app_next  = app_inc;
                        veto_next = veto_inc;
                        vrem_next = vrem_dec;
                        if (pst_reg == abort_reg && app_inc != '0)
                        begin
                            do_commit = 1'b1;
                        end
                        else if (veto_inc > max_veto_reg)
                        begin
                            do_clear = 1'b1;
                        end
                        else if (vrem_dec == '0 && app_inc >= min_app_reg)
                        begin
                            do_commit = 1'b1;
                        end
                    end
                end
                cvsm_pkg::CMD_TICK:
                begin
                    if (pend_reg)
                    begin
                        if (tmo_reg > 16'd1)
                        begin
                            tmo_next = tmo_reg - 16'd1;
                        end
                        else if (app_reg >= min_app_reg)
                        begin
                            do_commit = 1'b1;
                        end
                        else
                        begin
                            do_clear = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (do_commit)
        begin
            sys_next          = pst_reg;
            res.message_kind  = cvsm_pkg::KIND_COMMIT;
            res.message_tag   = ptag_reg;
            res.message_state = pst_reg;
        end

        if (do_commit || do_clear)
        begin
            pend_next = 1'b0;
            pst_next  = '0;
            ptag_next = '0;
            vrem_next = '0;
            app_next  = '0;
            veto_next = '0;
            tmo_next  = '0;
        end

        res.committed_state = sys_next;
        res.request_pending = pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_reg  <= cvsm_pkg::STATE_W'(RESET_STATE);
            pend_reg <= 1'b0;
            pst_reg  <= '0;
            ptag_reg <= '0;
            vrem_reg <= '0;
            app_reg  <= '0;
            veto_reg <= '0;
            tmo_reg  <= '0;
        end
        else
        begin
            sys_reg  <= sys_next;
            pend_reg <= pend_next;
            pst_reg  <= pst_next;
            ptag_reg <= ptag_next;
            vrem_reg <= vrem_next;
            app_reg  <= app_next;
            veto_reg <= veto_next;
            tmo_reg  <= tmo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TBL_DEPTH; i++)
            begin
                tbl_reg[i] <= '0;
            end
        end
        else if (tbl_we)
        begin
            tbl_reg[tbl_idx] <= ev.confidence_value;
        end
    end

endmodule

// File: sv/cvsm_out_stage.sv
// result register stage: holds one result until the downstream transfer
`timescale 1ns / 1ps

module cvsm_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  cvsm_pkg::result_t    res_in,
    input  logic                 out_ready,
    output logic                 out_valid,
    output cvsm_pkg::result_t    res_out,
    output logic                 advance
);

    logic              valid_reg;
    logic              valid_next;
    cvsm_pkg::result_t res_reg;

    assign advance    = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

// File: sv/consensus_vote_state_manager_core.sv
// top level of the consensus vote state manager
`timescale 1ns / 1ps

// path: input register, combinational engine, result register driving m_axis
// throughput: one event per cycle while m_axis is ready; the engine handles a whole event
//   combinationally between the input register and the result register
// backpressure stalls both stages; the input register refills in the cycle it drains
// reset: rst_n asynchronous, clears valid flags, config to defaults, request state,
//   and the confidence table at once; no clearing pass

module consensus_vote_state_manager_core
#(
    parameter int NUM_STATES  = cvsm_pkg::NUM_STATES_DEF,
    parameter int RESET_STATE = cvsm_pkg::RESET_STATE_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,

    // configuration write port
    input  logic                                cfg_we,
    input  logic [cvsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cvsm_pkg::CFG_DW-1:0]         cfg_data,

    // event stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // target_state[3:0], confidence_value[11:4], request_tag[43:12],
    // vote_code[51:44], live_boards[59:52], payload_length[63:60]
    input  logic [cvsm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // command[2:0]
    input  logic [cvsm_pkg::CMD_W-1:0]          s_axis_tuser,

    // message stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // message_tag[31:0], message_state[35:32], our_vote[37:36],
    // committed_state[41:38], request_pending[42], zero pad[47:43]
    output logic [cvsm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // message_kind[1:0]
    output logic [cvsm_pkg::KIND_W-1:0]         m_axis_tuser
);

    cvsm_pkg::event_t  in_event;
    cvsm_pkg::event_t  ev;
    cvsm_pkg::result_t res_comb;
    cvsm_pkg::result_t res_out;
    cvsm_pkg::flow_t   flow;
    logic              ev_valid;
    logic              advance;

    // unpack the event transfer
    assign in_event.command          = s_axis_tuser;
    assign in_event.target_state     = s_axis_tdata[3:0];
    assign in_event.confidence_value = s_axis_tdata[11:4];
    assign in_event.request_tag      = s_axis_tdata[43:12];
    assign in_event.vote_code        = s_axis_tdata[51:44];
    assign in_event.live_boards      = s_axis_tdata[59:52];
    assign in_event.payload_length   = s_axis_tdata[63:60];

    // input register, refilled while the engine drains it
    cvsm_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_event (in_event),
        .advance  (advance),
        .ev_valid (ev_valid),
        .ev       (ev)
    );

    assign flow.valid   = ev_valid;
    assign flow.advance = advance;

    // state updates commit only when the result register can take the result
    cvsm_engine
    #(
        .NUM_STATES  (NUM_STATES),
        .RESET_STATE (RESET_STATE)
    )
    u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .flow      (flow),
        .ev        (ev),
        .res       (res_comb)
    );

    cvsm_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (ev_valid && advance),
        .res_in    (res_comb),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .res_out   (res_out),
        .advance   (advance)
    );

    // pack the message transfer
    assign m_axis_tuser = res_out.message_kind;
    assign m_axis_tdata = {5'd0,
                           res_out.request_pending,
                           res_out.committed_state,
                           res_out.our_vote,
                           res_out.message_state,
                           res_out.message_tag};

endmodule

// File: sv/cvsm_checker.sv
// port-level checks of the consensus vote state manager, bound to the top level
`timescale 1ns / 1ps

module cvsm_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [cvsm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input logic [cvsm_pkg::KIND_W-1:0]        m_axis_tuser
);

    // a stalled result transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // nothing is offered right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result offered right after reset");

    // a commit installs its state and clears the request
    a_commit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == cvsm_pkg::KIND_COMMIT |->
            m_axis_tdata[41:38] == m_axis_tdata[35:32] && !m_axis_tdata[42])
        else $error("commit inconsistent with committed state");

    // a request broadcast leaves a request pending
    a_request: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == cvsm_pkg::KIND_REQUEST |-> m_axis_tdata[42])
        else $error("request broadcast without pending request");

    // only a vote reply carries a vote other than abstain
    a_vote_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != cvsm_pkg::KIND_VOTE |->
            m_axis_tdata[37:36] == cvsm_pkg::REPLY_ABSTAIN)
        else $error("vote carried outside a vote reply");

endmodule

bind consensus_vote_state_manager_core cvsm_checker u_cvsm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: bench/consensus_vote_state_manager_core_tb.sv
// self-checking testbench for the consensus vote state manager core
`timescale 1ns / 1ps

module consensus_vote_state_manager_core_tb;

    // clock, reset and every block input start at known values
    logic                                 clk           = 1'b0;
    logic                                 rst_n         = 1'b0;
    logic                                 cfg_we        = 1'b0;
    logic [cvsm_pkg::CFG_IDX_W-1:0]       cfg_index     = '0;
    logic [cvsm_pkg::CFG_DW-1:0]          cfg_data      = '0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    // target_state, confidence_value, request_tag, vote_code, live_boards, payload_length
    logic [cvsm_pkg::IN_TDATA_W-1:0]      s_axis_tdata  = '0;
    // command
    logic [cvsm_pkg::CMD_W-1:0]           s_axis_tuser  = '0;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    // message_tag, message_state, our_vote, committed_state, request_pending, zero pad
    logic [cvsm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;
    // message_kind
    logic [cvsm_pkg::KIND_W-1:0]          m_axis_tuser;

    consensus_vote_state_manager_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: a private copy of the vote manager and its registers
    // ------------------------------------------------------------------
    logic [cvsm_pkg::CNT_W-1:0]   min_approvals_cfg = cvsm_pkg::MIN_APPROVALS_RST;
    logic [cvsm_pkg::CNT_W-1:0]   max_vetoes_cfg    = cvsm_pkg::MAX_VETOES_RST;
    logic [cvsm_pkg::CONF_W-1:0]  veto_level        = cvsm_pkg::VETO_CONF_RST;
    logic [cvsm_pkg::CONF_W-1:0]  approve_level     = cvsm_pkg::APPROVE_CONF_RST;
    logic [cvsm_pkg::STATE_W-1:0] abort_code        = cvsm_pkg::ABORT_STATE_RST;
    logic [cvsm_pkg::TMO_W-1:0]   timeout_cfg       = cvsm_pkg::TIMEOUT_TICKS_RST;

    logic [cvsm_pkg::STATE_W-1:0] cur_state  =
        cvsm_pkg::RESET_STATE_DEF[cvsm_pkg::STATE_W-1:0];
    logic                         req_active = 1'b0;
    logic [cvsm_pkg::STATE_W-1:0] req_state  = '0;
    logic [cvsm_pkg::TAG_W-1:0]   req_tag    = '0;
    logic [cvsm_pkg::CNT_W-1:0]   votes_left = '0;
    logic [cvsm_pkg::CNT_W-1:0]   approvals  = '0;
    logic [cvsm_pkg::CNT_W-1:0]   vetoes     = '0;
    logic [cvsm_pkg::TMO_W-1:0]   ticks_left = '0;
    logic [cvsm_pkg::CONF_W-1:0]  confidence [cvsm_pkg::NUM_STATES_DEF] = '{default: '0};

    // messages still owed by the block, oldest first
    cvsm_pkg::result_t expected_msgs [$];
    int                mismatches = 0;
    int                sent_count = 0;

    // stimulus knobs
    bit tx_gaps_on = 1'b1;
    bit rx_gaps_on = 1'b1;
    int long_hold  = 0;

    function automatic void clear_request();
        req_active = 1'b0;
        req_state  = '0;
        req_tag    = '0;
        votes_left = '0;
        approvals  = '0;
        vetoes     = '0;
        ticks_left = '0;
    endfunction

    // the pending request becomes the system state and goes out as a commit
    function automatic void commit_request(inout cvsm_pkg::result_t r);
        cur_state       = req_state;
        r.message_kind  = cvsm_pkg::KIND_COMMIT;
        r.message_tag   = req_tag;
        r.message_state = req_state;
        clear_request();
    endfunction

    // our answer to a peer's request, from the confidence table
    function automatic logic [cvsm_pkg::VOTE_W-1:0] opinion_of(
        logic [cvsm_pkg::STATE_W-1:0] st);
        logic [cvsm_pkg::CONF_W-1:0] c;
        c = (int'(st) < cvsm_pkg::NUM_STATES_DEF) ? confidence[st] : '0;
        if (c < veto_level)
            return cvsm_pkg::REPLY_VETO;
        if (c > approve_level)
            return cvsm_pkg::REPLY_APPROVE;
        return cvsm_pkg::REPLY_ABSTAIN;
    endfunction

    // applies one event to the private copy and returns the message it causes
    function automatic cvsm_pkg::result_t predict_message(cvsm_pkg::event_t ev);
        cvsm_pkg::result_t r;
        r          = '0;
        r.our_vote = cvsm_pkg::REPLY_ABSTAIN;
        case (ev.command)
            cvsm_pkg::CMD_CONF_UPDATE:
            begin
                if (int'(ev.target_state) < cvsm_pkg::NUM_STATES_DEF)
                    confidence[ev.target_state] = ev.confidence_value;
            end
            cvsm_pkg::CMD_START_REQ:
            begin
                // a new request simply replaces one still pending
                req_active      = 1'b1;
                req_state       = ev.target_state;
                req_tag         = ev.request_tag;
                votes_left      = ev.live_boards;
                approvals       = '0;
                vetoes          = '0;
                ticks_left      = timeout_cfg;
                r.message_kind  = cvsm_pkg::KIND_REQUEST;
                r.message_tag   = ev.request_tag;
                r.message_state = ev.target_state;
            end
            cvsm_pkg::CMD_PEER_REQ:
            begin
                if (ev.payload_length >= cvsm_pkg::MIN_REQ_LEN)
                begin
                    r.message_kind = cvsm_pkg::KIND_VOTE;
                    r.message_tag  = ev.request_tag;
                    r.our_vote     = opinion_of(ev.target_state);
                end
            end
            cvsm_pkg::CMD_PEER_VOTE:
            begin
                if (ev.payload_length >= cvsm_pkg::MIN_VOTE_LEN && req_active &&
                    ev.request_tag == req_tag)
                begin
                    // counters saturate, remaining votes stop at zero
                    if (ev.vote_code == cvsm_pkg::PEER_APPROVE)
                    begin
                        if (approvals != cvsm_pkg::CNT_MAX)
                            approvals = approvals + 8'd1;
                    end
                    else if (ev.vote_code == cvsm_pkg::PEER_VETO)
                    begin
                        if (vetoes != cvsm_pkg::CNT_MAX)
                            vetoes = vetoes + 8'd1;
                    end
                    if (votes_left != 8'd0)
                        votes_left = votes_left - 8'd1;
                    if (req_state == abort_code && approvals != 8'd0)
                        commit_request(r);
                    else if (vetoes > max_vetoes_cfg)
                        clear_request();
                    else if (votes_left == 8'd0 && approvals >= min_approvals_cfg)
                        commit_request(r);
                end
            end
            cvsm_pkg::CMD_TICK:
            begin
                if (req_active)
                begin
                    if (ticks_left > 16'd1)
                        ticks_left = ticks_left - 16'd1;
                    else if (approvals >= min_approvals_cfg)
                        commit_request(r);
                    else
                        clear_request();
                end
            end
            default:
            begin
            end
        endcase
        r.committed_state = cur_state;
        r.request_pending = req_active;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // scoreboard: outputs checked first, then the input transfer of the
    // same edge is predicted; the block's latency keeps the two apart
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        cvsm_pkg::result_t seen;
        cvsm_pkg::result_t want;
        cvsm_pkg::event_t  ev;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.message_kind    = m_axis_tuser;
            seen.message_tag     = m_axis_tdata[31:0];
            seen.message_state   = m_axis_tdata[35:32];
            seen.our_vote        = m_axis_tdata[37:36];
            seen.committed_state = m_axis_tdata[41:38];
            seen.request_pending = m_axis_tdata[42];
            if (expected_msgs.size() == 0)
            begin
                $display("%0t: unexpected message, expected none, actual %h", $time, seen);
                mismatches++;
            end
            else
            begin
                want = expected_msgs.pop_front();
                check_field("message_kind", 32'(want.message_kind), 32'(seen.message_kind));
                check_field("message_tag", want.message_tag, seen.message_tag);
                check_field("message_state", 32'(want.message_state),
                            32'(seen.message_state));
                check_field("our_vote", 32'(want.our_vote), 32'(seen.our_vote));
                check_field("committed_state", 32'(want.committed_state),
                            32'(seen.committed_state));
                check_field("request_pending", 32'(want.request_pending),
                            32'(seen.request_pending));
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            ev.command = s_axis_tuser;
            {ev.payload_length, ev.live_boards, ev.vote_code, ev.request_tag,
             ev.confidence_value, ev.target_state} = s_axis_tdata;
            expected_msgs.push_back(predict_message(ev));
        end
    end

    // ------------------------------------------------------------------
    // receiver: ready with random stall bursts, or a long counted hold-off
    // when the stimulus asks for one
    // ------------------------------------------------------------------
    always
    begin : rx_side
        int n;
        @(negedge clk);
        if (long_hold > 0)
        begin
            n         = long_hold;
            long_hold = 0;
            m_axis_tready <= 1'b0;
            repeat (n) @(negedge clk);
            m_axis_tready <= 1'b1;
        end
        else if (rx_gaps_on && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
            m_axis_tready <= 1'b1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // sender side helpers, all entered and left at a falling edge
    // ------------------------------------------------------------------

    // one event transfer, preceded now and then by an idle burst;
    // valid stays high on return so back-to-back events need no re-raise
    task automatic send_event(cvsm_pkg::event_t ev);
        if (tx_gaps_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_axis_tdata  <= {ev.payload_length, ev.live_boards, ev.vote_code, ev.request_tag,
                          ev.confidence_value, ev.target_state};
        s_axis_tuser  <= ev.command;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_count++;
        @(negedge clk);
    endtask

    function automatic cvsm_pkg::event_t make_event(
        logic [cvsm_pkg::CMD_W-1:0] cmd, logic [cvsm_pkg::STATE_W-1:0] tgt,
        logic [cvsm_pkg::CONF_W-1:0] conf, logic [cvsm_pkg::TAG_W-1:0] tag,
        logic [cvsm_pkg::CNT_W-1:0] vcode, logic [cvsm_pkg::CNT_W-1:0] live,
        logic [cvsm_pkg::LEN_W-1:0] plen);
        cvsm_pkg::event_t ev;
        ev.command          = cmd;
        ev.target_state     = tgt;
        ev.confidence_value = conf;
        ev.request_tag      = tag;
        ev.vote_code        = vcode;
        ev.live_boards      = live;
        ev.payload_length   = plen;
        return ev;
    endfunction

    // any command, unused codes included, every field at random
    function automatic cvsm_pkg::event_t random_event();
        cvsm_pkg::event_t ev;
        ev.command          = 3'($urandom_range(0, 7));
        ev.target_state     = 4'($urandom);
        ev.confidence_value = 8'($urandom);
        ev.request_tag      = $urandom;
        ev.vote_code        = 8'($urandom);
        ev.live_boards      = 8'($urandom);
        ev.payload_length   = 4'($urandom);
        return ev;
    endfunction

    // stop offering and wait until every owed message is out and the pipe is empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_msgs.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // writes all seven registers back to back; only called with the block idle
    task automatic program_config(logic [7:0] alias_v, logic [7:0] min_v, logic [7:0] maxv_v,
                                  logic [7:0] veto_v, logic [7:0] appr_v,
                                  logic [3:0] abort_v, logic [15:0] tmo_v);
        logic [cvsm_pkg::CFG_IDX_W-1:0] idx  [7];
        logic [cvsm_pkg::CFG_DW-1:0]    vals [7];
        idx  = '{cvsm_pkg::REG_OWN_ALIAS, cvsm_pkg::REG_MIN_APPROVALS,
                 cvsm_pkg::REG_MAX_VETOES, cvsm_pkg::REG_VETO_CONF,
                 cvsm_pkg::REG_APPROVE_CONF, cvsm_pkg::REG_ABORT_STATE,
                 cvsm_pkg::REG_TIMEOUT_TICKS};
        vals = '{16'(alias_v), 16'(min_v), 16'(maxv_v), 16'(veto_v), 16'(appr_v),
                 16'(abort_v), tmo_v};
        for (int i = 0; i < 7; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        min_approvals_cfg = min_v;
        max_vetoes_cfg    = maxv_v;
        veto_level        = veto_v;
        approve_level     = appr_v;
        abort_code        = abort_v;
        timeout_cfg       = tmo_v;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset register values: ignored events, table reads, abort, veto cancel,
    // request replacement and full turnout
    task automatic test_directed_events();
        // tick with nothing pending, then the unused command codes
        send_event(make_event(cvsm_pkg::CMD_TICK, 4'd0, 8'd0, 32'd0, 8'd0, 8'd0, 4'd0));
        for (int c = cvsm_pkg::CMD_TICK + 1; c < 8; c++)
            send_event(make_event(c[cvsm_pkg::CMD_W-1:0], 4'hF, 8'hFF, 32'hFFFF_FFFF, 8'hFF,
                                  8'hFF, 4'hF));
        // confidence extremes and values right at the thresholds
        send_event(make_event(cvsm_pkg::CMD_CONF_UPDATE, 4'd0, 8'd0, 32'd0, 8'd0, 8'd0, 4'd0));
        send_event(make_event(cvsm_pkg::CMD_CONF_UPDATE, 4'd15, 8'd255, 32'd0, 8'd0, 8'd0,
                              4'd0));
        send_event(make_event(cvsm_pkg::CMD_CONF_UPDATE, 4'd2, cvsm_pkg::VETO_CONF_RST, 32'd0,
                              8'd0, 8'd0, 4'd0));
        send_event(make_event(cvsm_pkg::CMD_CONF_UPDATE, 4'd3, cvsm_pkg::APPROVE_CONF_RST,
                              32'd0, 8'd0, 8'd0, 4'd0));
        send_event(make_event(cvsm_pkg::CMD_CONF_UPDATE, 4'd4,
                              cvsm_pkg::APPROVE_CONF_RST + 8'd1, 32'd0, 8'd0, 8'd0, 4'd0));
        // peer requests: veto, approve, two abstains, another approve, and a short one that is dropped
        send_event(make_event(cvsm_pkg::CMD_PEER_REQ, 4'd0, 8'd0, 32'h0000_0001, 8'd0, 8'd0,
                              cvsm_pkg::MIN_REQ_LEN));
        send_event(make_event(cvsm_pkg::CMD_PEER_REQ, 4'd15, 8'd0, 32'h8000_0000, 8'd0, 8'd0,
                              4'd8));
        send_event(make_event(cvsm_pkg::CMD_PEER_REQ, 4'd2, 8'd0, 32'hDEAD_BEEF, 8'd0, 8'd0,
                              4'd15));
        send_event(make_event(cvsm_pkg::CMD_PEER_REQ, 4'd3, 8'd0, 32'h0F0F_0F0F, 8'd0, 8'd0,
                              cvsm_pkg::MIN_REQ_LEN));
        send_event(make_event(cvsm_pkg::CMD_PEER_REQ, 4'd4, 8'd0, 32'h7FFF_FFFF, 8'd0, 8'd0,
                              cvsm_pkg::MIN_REQ_LEN));
        send_event(make_event(cvsm_pkg::CMD_PEER_REQ, 4'd15, 8'd0, 32'h1111_1111, 8'd0, 8'd0,
                              cvsm_pkg::MIN_REQ_LEN - 4'd1));
        // abort request: short vote and foreign tag ignored, abstain counted,
        // the first approval commits
        send_event(make_event(cvsm_pkg::CMD_START_REQ, cvsm_pkg::ABORT_STATE_RST, 8'd0,
                              32'hFFFF_FFFF, 8'd0, 8'd3, 4'd0));
        send_event(make_event(cvsm_pkg::CMD_PEER_VOTE, 4'd0, 8'd0, 32'hFFFF_FFFF,
                              cvsm_pkg::PEER_APPROVE, 8'd0, cvsm_pkg::MIN_VOTE_LEN - 4'd1));
        send_event(make_event(cvsm_pkg::CMD_PEER_VOTE, 4'd0, 8'd0, 32'h0,
                              cvsm_pkg::PEER_APPROVE, 8'd0, cvsm_pkg::MIN_VOTE_LEN));
        send_event(make_event(cvsm_pkg::CMD_PEER_VOTE, 4'd0, 8'd0, 32'hFFFF_FFFF, 8'h80, 8'd0,
                              cvsm_pkg::MIN_VOTE_LEN));
        send_event(make_event(cvsm_pkg::CMD_PEER_VOTE, 4'd0, 8'd0, 32'hFFFF_FFFF,
                              cvsm_pkg::PEER_APPROVE, 8'd0, cvsm_pkg::MIN_VOTE_LEN));
        // a single veto exceeds the tolerated count and cancels
        send_event(make_event(cvsm_pkg::CMD_START_REQ, 4'd5, 8'd0, 32'd0, 8'd0, 8'd255, 4'd0));
        send_event(make_event(cvsm_pkg::CMD_PEER_VOTE, 4'd0, 8'd0, 32'd0, cvsm_pkg::PEER_VETO,
                              8'd0, 4'd15));
        // second start replaces the first; old tag no longer counts
        send_event(make_event(cvsm_pkg::CMD_START_REQ, 4'd6, 8'd0, 32'h0000_1234, 8'd0, 8'd1,
                              4'd0));
        send_event(make_event(cvsm_pkg::CMD_START_REQ, 4'd7, 8'd0, 32'h0000_5678, 8'd0, 8'd2,
                              4'd0));
        send_event(make_event(cvsm_pkg::CMD_PEER_VOTE, 4'd0, 8'd0, 32'h0000_1234,
                              cvsm_pkg::PEER_APPROVE, 8'd0, 4'd3));
        send_event(make_event(cvsm_pkg::CMD_PEER_VOTE, 4'd0, 8'd0, 32'h0000_5678,
                              cvsm_pkg::PEER_APPROVE, 8'd0, 4'd3));
        send_event(make_event(cvsm_pkg::CMD_PEER_VOTE, 4'd0, 8'd0, 32'h0000_5678, 8'hFF, 8'd0,
                              4'd3));
    endtask

    // threshold registers at both extremes
    task automatic test_vote_thresholds();
        settle();
        program_config(8'h3C, 8'd1, 8'd0, 8'd0, 8'd255, 4'd1, 16'd100);
        send_event(make_event(cvsm_pkg::CMD_PEER_REQ, 4'd0, 8'd0, 32'hA5A5_A5A5, 8'd0, 8'd0,
                              4'd7));
        send_event(make_event(cvsm_pkg::CMD_PEER_REQ, 4'd15, 8'd0, 32'h5A5A_5A5A, 8'd0, 8'd0,
                              4'd7));
        settle();
        program_config(8'hC3, 8'd1, 8'd0, 8'd255, 8'd0, 4'd1, 16'd100);
        send_event(make_event(cvsm_pkg::CMD_PEER_REQ, 4'd15, 8'd0, 32'h0000_00FF, 8'd0, 8'd0,
                              4'd6));
        send_event(make_event(cvsm_pkg::CMD_PEER_REQ, 4'd0, 8'd0, 32'hFF00_0000, 8'd0, 8'd0,
                              4'd6));
        send_event(make_event(cvsm_pkg::CMD_PEER_REQ, 4'd2, 8'd0, 32'h00FF_0000, 8'd0, 8'd0,
                              4'd6));
    endtask

    // timeouts of zero, one and a few ticks; surplus votes; all-ones registers
    task automatic test_timeouts();
        settle();
        // zero timeout fires on the first tick, no approvals so it clears
        program_config(8'h00, 8'd1, 8'd0, 8'd64, 8'd192, 4'd1, 16'd0);
        send_event(make_event(cvsm_pkg::CMD_START_REQ, 4'd3, 8'd0, 32'h0000_0A0A, 8'd0, 8'd2,
                              4'd0));
        send_event(make_event(cvsm_pkg::CMD_TICK, 4'd0, 8'd0, 32'd0, 8'd0, 8'd0, 4'd0));
        settle();
        // nothing needed, a one-tick timeout commits with no approvals
        program_config(8'h01, 8'd0, 8'd0, 8'd64, 8'd192, 4'd1, 16'd1);
        send_event(make_event(cvsm_pkg::CMD_START_REQ, 4'd4, 8'd0, 32'h0000_0B0B, 8'd0, 8'd2,
                              4'd0));
        send_event(make_event(cvsm_pkg::CMD_TICK, 4'd0, 8'd0, 32'd0, 8'd0, 8'd0, 4'd0));
        settle();
        program_config(8'h02, 8'd2, 8'd0, 8'd64, 8'd192, 4'd0, 16'd3);
        // no votes expected: every vote is surplus and counts as full turnout
        send_event(make_event(cvsm_pkg::CMD_START_REQ, 4'd5, 8'd0, 32'h0000_0C0C, 8'd0, 8'd0,
                              4'd0));
        send_event(make_event(cvsm_pkg::CMD_PEER_VOTE, 4'd0, 8'd0, 32'h0000_0C0C,
                              cvsm_pkg::PEER_APPROVE, 8'd0, 4'd4));
        send_event(make_event(cvsm_pkg::CMD_TICK, 4'd0, 8'd0, 32'd0, 8'd0, 8'd0, 4'd0));
        send_event(make_event(cvsm_pkg::CMD_TICK, 4'd0, 8'd0, 32'd0, 8'd0, 8'd0, 4'd0));
        send_event(make_event(cvsm_pkg::CMD_PEER_VOTE, 4'd0, 8'd0, 32'h0000_0C0C,
                              cvsm_pkg::PEER_APPROVE, 8'd0, 4'd4));
        // timeout short of approvals clears the request
        send_event(make_event(cvsm_pkg::CMD_START_REQ, 4'd6, 8'd0, 32'h0000_0D0D, 8'd0, 8'd9,
                              4'd0));
        send_event(make_event(cvsm_pkg::CMD_PEER_VOTE, 4'd0, 8'd0, 32'h0000_0D0D,
                              cvsm_pkg::PEER_APPROVE, 8'd0, 4'd4));
        repeat (3)
            send_event(make_event(cvsm_pkg::CMD_TICK, 4'd0, 8'd0, 32'd0, 8'd0, 8'd0, 4'd0));
        settle();
        // every register at its top value
        program_config(8'hFF, 8'd255, 8'd255, 8'd255, 8'd255, 4'd15, 16'hFFFF);
        send_event(make_event(cvsm_pkg::CMD_PEER_REQ, 4'd15, 8'd0, 32'h1234_5678, 8'd0, 8'd0,
                              4'd8));
        send_event(make_event(cvsm_pkg::CMD_PEER_REQ, 4'd0, 8'd0, 32'h8765_4321, 8'd0, 8'd0,
                              4'd8));
        send_event(make_event(cvsm_pkg::CMD_START_REQ, 4'd15, 8'd0, 32'h0000_0E0E, 8'd0, 8'd4,
                              4'd0));
        send_event(make_event(cvsm_pkg::CMD_TICK, 4'd0, 8'd0, 32'd0, 8'd0, 8'd0, 4'd0));
        send_event(make_event(cvsm_pkg::CMD_PEER_VOTE, 4'd0, 8'd0, 32'h0000_0E0E,
                              cvsm_pkg::PEER_APPROVE, 8'd0, 4'd8));
    endtask

    // the veto counter runs into its ceiling without cancelling, then an
    // approval completes the request
    task automatic test_veto_saturation();
        settle();
        program_config(8'h81, 8'd1, 8'd255, 8'd64, 8'd192, 4'd15, 16'hFFFF);
        send_event(make_event(cvsm_pkg::CMD_START_REQ, 4'd9, 8'd0, 32'hCAFE_F00D, 8'd0, 8'd0,
                              4'd0));
        repeat (258)
            send_event(make_event(cvsm_pkg::CMD_PEER_VOTE, 4'd0, 8'd0, 32'hCAFE_F00D,
                                  cvsm_pkg::PEER_VETO, 8'd0, 4'd3));
        send_event(make_event(cvsm_pkg::CMD_PEER_VOTE, 4'd0, 8'd0, 32'hCAFE_F00D,
                              cvsm_pkg::PEER_APPROVE, 8'd0, 4'd3));
    endtask

    // one request followed by votes on it, mixed with ticks and other traffic,
    // until the request resolves or the session runs long
    task automatic run_session();
        cvsm_pkg::event_t           ev;
        logic [cvsm_pkg::TAG_W-1:0] tag;
        int                         len;
        tag            = $urandom;
        ev             = random_event();
        ev.command     = cvsm_pkg::CMD_START_REQ;
        ev.request_tag = tag;
        if ($urandom_range(0, 3) == 0)
            ev.target_state = abort_code;
        ev.live_boards = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        send_event(ev);
        len = 0;
        // the scoreboard has already applied the last transfer on return
        while (req_active && len < 16)
        begin
            ev = random_event();
            case ($urandom_range(0, 9))
                0: ev.command = cvsm_pkg::CMD_TICK;
                1: ev.command = cvsm_pkg::CMD_PEER_REQ;
                2: ev.command = cvsm_pkg::CMD_CONF_UPDATE;
                3: ev.command = cvsm_pkg::CMD_PEER_VOTE;
                default:
                begin
                    ev.command        = cvsm_pkg::CMD_PEER_VOTE;
                    ev.request_tag    = tag;
                    ev.payload_length = 4'($urandom_range(cvsm_pkg::MIN_VOTE_LEN, 15));
                    if ($urandom_range(0, 4) != 0)
                        ev.vote_code = ($urandom_range(0, 1) == 0) ? cvsm_pkg::PEER_APPROVE :
                                                                     cvsm_pkg::PEER_VETO;
                end
            endcase
            send_event(ev);
            len++;
        end
    endtask

    // sessions and noise until at least n events have gone in
    task automatic random_traffic(int n);
        int start;
        start = sent_count;
        while (sent_count - start < n)
        begin
            if ($urandom_range(0, 4) == 0)
                send_event(random_event());
            else
                run_session();
        end
    endtask

    task automatic test_random_sessions();
        for (int phase = 0; phase < 4; phase++)
        begin
            settle();
            tx_gaps_on = (phase != 1);
            rx_gaps_on = (phase != 2);
            program_config(8'($urandom), 8'($urandom_range(0, 3)), 8'($urandom_range(0, 2)),
                           8'($urandom), 8'($urandom), 4'($urandom_range(0, 15)),
                           16'($urandom_range(1, 8)));
            random_traffic(30);
        end
    endtask

    // receiver holds off for a long counted stretch while events keep coming,
    // so the block fills and drops tready
    task automatic test_backpressure();
        settle();
        tx_gaps_on = 1'b0;
        long_hold  = 80;
        repeat (40)
            send_event(random_event());
        tx_gaps_on = 1'b1;
    endtask

    // last stretch with no idling on either side
    task automatic test_full_rate();
        settle();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        program_config(8'($urandom), 8'($urandom_range(0, 2)), 8'($urandom_range(0, 1)),
                       8'($urandom_range(0, 100)), 8'($urandom_range(150, 255)),
                       4'($urandom_range(0, 15)), 16'($urandom_range(1, 4)));
        random_traffic(70);
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------
    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_events();
        test_vote_thresholds();
        test_timeouts();
        test_veto_saturation();
        test_backpressure();
        test_random_sessions();
        test_full_rate();
        settle();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
